FILE: hdl/arpc_pkg.sv
package arpc_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam int REQ_W       = 2;
	localparam int IP_W        = 32;
	localparam int MAC_W       = 48;
	localparam int AGE_W       = 8;
	localparam int STAT_W      = 2;
	localparam int SLOT_W      = 5;

	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
	localparam logic [STAT_W-1:0] ST_NONE = 2'd3;

	localparam logic [AGE_W-1:0] AGE_MAX     = 8'hFF;
	localparam logic [AGE_W-1:0] TIMEOUT_RST = 8'd15;

	typedef struct packed {
		logic             vld;
		logic [REQ_W-1:0] kind;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} arpc_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [MAC_W-1:0]  mac;
		logic [SLOT_W-1:0] slot;
	} arpc_rsp_t;

endpackage

FILE: hdl/arpc_table.sv
module arpc_table #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  arpc_pkg::arpc_req_t          req,
	input  logic [arpc_pkg::AGE_W-1:0]   timeout,
	output arpc_pkg::arpc_rsp_t          rsp
);
	import arpc_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [ENTRIES-1:0] valid_q;
	logic [IP_W-1:0]    ip_q  [ENTRIES];
	logic [MAC_W-1:0]   mac_q [ENTRIES];
	logic [AGE_W-1:0]   age_q [ENTRIES];

	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] hit_oh;
	logic [ENTRIES-1:0] free_oh;
	logic [IDX_W-1:0]   hit_idx;
	logic [IDX_W-1:0]   free_idx;
	logic [MAC_W-1:0]   hit_mac;
	logic [AGE_W-1:0]   age_nxt [ENTRIES];
	logic               do_add;
	logic               do_tick;

	// parallel compare, lowest set bit isolated as v & -v
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i]  = valid_q[i] && (ip_q[i] == req.ip);
			free_vec[i] = !valid_q[i];
			age_nxt[i]  = (age_q[i] == AGE_MAX) ? age_q[i] : age_q[i] + 1'b1;
		end
		hit_oh   = hit_vec & (~hit_vec + ENTRIES'(1));
		free_oh  = free_vec & (~free_vec + ENTRIES'(1));
		hit_idx  = '0;
		free_idx = '0;
		hit_mac  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_oh[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
				hit_mac = hit_mac | mac_q[i];
			end
			if (free_oh[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

	assign do_add  = req.vld && (req.kind == REQ_ADD) && (|free_vec);
	assign do_tick = req.vld && (req.kind == REQ_TICK);

	always_comb begin
		rsp = '{status: ST_OK, mac: '0, slot: '0};
		case (req.kind)
			REQ_LOOKUP: begin
				if (|hit_vec) begin
					rsp.mac  = hit_mac;
					rsp.slot = SLOT_W'(hit_idx);
				end else begin
					rsp.status = ST_MISS;
				end
			end
			REQ_ADD: begin
				if (|free_vec) begin
					rsp.slot = SLOT_W'(free_idx);
				end else begin
					rsp.status = ST_FULL;
				end
			end
			default: begin
				rsp.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_add && free_oh[i]) begin
					valid_q[i] <= 1'b1;
				end else if (do_tick && valid_q[i] && (age_nxt[i] > timeout)) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (do_add && free_oh[i]) begin
				ip_q[i]  <= req.ip;
				mac_q[i] <= req.mac;
				age_q[i] <= '0;
			end else if (do_tick) begin
				age_q[i] <= age_nxt[i];
			end
		end
	end

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_oh) && $onehot0(free_oh))
		else $error("priority select not one-hot");

	a_add_fills: assert property (@(posedge clk) disable iff (!arst_n)
		do_add |=> valid_q[$past(free_idx)])
		else $error("add did not mark slot valid");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(req.vld && req.kind == REQ_ADD && valid_q == '1) |-> rsp.status == ST_FULL)
		else $error("full table not reported");

endmodule

FILE: hdl/arp_cache_with_aging_core.sv
// channel  | ports                                     | handshake
// request  | req_type, ip_addr, mac_addr               | start & !busy
// result   | status, found_mac, slot                   | done, one cycle
// config   | timeout_wdata                             | timeout_we
// One beat per cycle: an accepted request is captured in the input register (s1),
// and its result is captured in the result register (s2), which raises done.
// busy stays low; every cycle may carry a new request.
// The table compare and update happen in the same cycle, so back-to-back
// requests see each other's effects in order.
// arst_n clears valid bits, pipeline valids and sets the timeout to 15.
// The receiver cannot stall; results are never held.
module arp_cache_with_aging_core #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [arpc_pkg::REQ_W-1:0]    req_type,
	input  logic [arpc_pkg::IP_W-1:0]     ip_addr,
	input  logic [arpc_pkg::MAC_W-1:0]    mac_addr,
	input  logic                          timeout_we,
	input  logic [arpc_pkg::AGE_W-1:0]    timeout_wdata,
	output logic                          done,
	output logic [arpc_pkg::STAT_W-1:0]   status,
	output logic [arpc_pkg::MAC_W-1:0]    found_mac,
	output logic [arpc_pkg::SLOT_W-1:0]   slot
);
	import arpc_pkg::*;

	logic               vld_s1;
	logic [REQ_W-1:0]   kind_s1;
	logic [IP_W-1:0]    ip_s1;
	logic [MAC_W-1:0]   mac_s1;
	arpc_req_t          req_s1;
	arpc_rsp_t          rsp_comb;
	arpc_rsp_t          rsp_s2;
	logic               done_s2;
	logic [AGE_W-1:0]   timeout_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (timeout_we) begin
			timeout_q <= timeout_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= req_type;
		ip_s1   <= ip_addr;
		mac_s1  <= mac_addr;
		rsp_s2  <= rsp_comb;
	end

	assign req_s1 = '{vld: vld_s1, kind: kind_s1, ip: ip_s1, mac: mac_s1};

	arpc_table #(
		.ENTRIES(ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_s1),
		.timeout(timeout_q),
		.rsp    (rsp_comb)
	);

	assign done      = done_s2;
	assign status    = rsp_s2.status;
	assign found_mac = rsp_s2.mac;
	assign slot      = rsp_s2.slot;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##1 done)
		else $error("result missing two cycles after start");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!req_s1.vld |=> !done)
		else $error("result without request");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (found_mac == '0 && slot == '0 && status != ST_NONE))
		else $error("miss or full carries data");

endmodule
